// ===== sv/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types, constants and arithmetic helpers for the associated
// Legendre evaluator (command encoding, CORDIC and reciprocal tables).
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int VW = 58;   // Q25.32 value width
    localparam int AW = 34;   // Q2.30 angle / trig width, with headroom
    localparam int KW = 5;    // small integer factor width
    localparam int CORDIC_STEPS = 32;

    localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [AW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [VW-1:0] ONE_Q32     = 58'sd4294967296;
    localparam logic signed [VW-1:0] LIM_HI      = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] LIM_LO      = {1'b1, {(VW-1){1'b0}}};
    localparam logic [63:0] MAG_POS_MAX = 64'h01FF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_NEG_MAX = 64'h0200_0000_0000_0000;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_CORDIC, OP_TRIG, OP_MOV, OP_FSET, OP_FLO, OP_FHI,
        OP_FEND, OP_IMUL, OP_SUB, OP_SHIFT, OP_OUT, OP_OUTERR
    } op_t;

    typedef enum logic [2:0] {
        R_P0, R_P1, R_D0, R_D1, R_PM, R_T0, R_T1, R_T2
    } reg_sel_t;

    typedef enum logic [1:0] {
        C_COS, C_SIN, C_RECIP
    } coef_sel_t;

    typedef struct packed {
        op_t       op;
        reg_sel_t  src_a;
        reg_sel_t  src_b;
        reg_sel_t  dst;
        coef_sel_t coef;
        logic [KW-1:0] kval;   // CORDIC step, integer factor or reciprocal index
    } cmd_t;

    function automatic logic [29:0] atan_val(input logic [4:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000008;
            5'd28: r = 30'h00000004;
            5'd29: r = 30'h00000002;
            5'd30: r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

    // Q2.30 reciprocal of k, round(2^30 / k)
    function automatic logic [30:0] recip_val(input logic [3:0] k);
        logic [30:0] r;
        unique case (k)
            4'd0:  r = 31'd0;
            4'd1:  r = 31'd1073741824;
            4'd2:  r = 31'd536870912;
            4'd3:  r = 31'd357913941;
            4'd4:  r = 31'd268435456;
            4'd5:  r = 31'd214748365;
            4'd6:  r = 31'd178956971;
            4'd7:  r = 31'd153391689;
            4'd8:  r = 31'd134217728;
            4'd9:  r = 31'd119304647;
            4'd10: r = 31'd107374182;
            4'd11: r = 31'd97612893;
            4'd12: r = 31'd89478485;
            4'd13: r = 31'd82595525;
            4'd14: r = 31'd76695845;
            default: r = 31'd71582788;
        endcase
        return r;
    endfunction

    // magnitude plus sign back to a saturated value; msb is the clip flag
    function automatic logic [VW:0] sat_sign(input logic [63:0] u, input logic neg);
        logic [VW:0] r;
        if (neg) begin
            if (u > MAG_NEG_MAX) r = {1'b1, LIM_LO};
            else                 r = {1'b0, VW'(-u[VW-1:0])};
        end else begin
            if (u > MAG_POS_MAX) r = {1'b1, LIM_HI};
            else                 r = {1'b0, u[VW-1:0]};
        end
        return r;
    endfunction

    function automatic logic [VW:0] clip_wide(input logic signed [VW:0] v);
        logic [VW:0] r;
        if (v[VW] != v[VW-1]) r = v[VW] ? {1'b1, LIM_LO} : {1'b1, LIM_HI};
        else                  r = {1'b0, v[VW-1:0]};
        return r;
    endfunction

endpackage

// ===== sv/ale_ctrl.sv =====
// ----------------------------------------------------------------------------
// ale_ctrl
// Sequencer: walks CORDIC, seed and degree recurrence, issuing one datapath
// command per cycle.
// ----------------------------------------------------------------------------
module ale_ctrl
    import ale_pkg::*;
#(
    parameter int MAX_DEGREE = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [3:0] degree,
    input  logic [3:0] order,
    output logic       busy,
    output logic       done,
    output cmd_t       cmd
);

    localparam logic [3:0] MAXD = 4'(MAX_DEGREE);

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_TRIG, S_SEED, S_SEEDD, S_REC, S_DONE, S_DONE_ERR
    } state_t;

    state_t     state_reg;
    logic [3:0] n_reg, m_reg, i_reg;
    logic [4:0] step_reg;
    logic       done_reg;

    logic [3:0] n_in, m_in;
    logic [4:0] k1, k2, kseed, k2m;
    logic [4:0] ridx;

    assign n_in  = (degree > MAXD) ? MAXD : degree;
    assign m_in  = (order > MAXD) ? MAXD : order;
    assign k1    = {i_reg, 1'b0} - 5'd1;
    assign k2    = 5'(i_reg) + 5'(m_reg) - 5'd1;
    assign kseed = {i_reg, 1'b0} - 5'd1;
    assign k2m   = {m_reg, 1'b0} - 5'd1;
    assign ridx  = 5'(i_reg - m_reg);

    function automatic cmd_t fm(input logic [1:0] ph, input reg_sel_t s,
                                input coef_sel_t c, input reg_sel_t d,
                                input logic [4:0] k);
        cmd_t r;
        unique case (ph)
            2'd0: r.op = OP_FSET;
            2'd1: r.op = OP_FLO;
            2'd2: r.op = OP_FHI;
            default: r.op = OP_FEND;
        endcase
        r.src_a = s;
        r.src_b = s;
        r.dst   = d;
        r.coef  = c;
        r.kval  = k;
        return r;
    endfunction

    function automatic cmd_t op2(input op_t o, input reg_sel_t a, input reg_sel_t b,
                                 input reg_sel_t d, input logic [4:0] k);
        cmd_t r;
        r.op = o; r.src_a = a; r.src_b = b; r.dst = d; r.coef = C_COS; r.kval = k;
        return r;
    endfunction

    always_comb
    begin
        cmd = op2(OP_NOP, R_P0, R_P0, R_P0, 5'd0);
        unique case (state_reg)
            S_IDLE:     if (start) cmd = op2(OP_LOAD, R_P0, R_P0, R_P0, 5'd0);
            S_CORDIC:   cmd = op2(OP_CORDIC, R_P0, R_P0, R_P0, step_reg);
            S_TRIG:     cmd = op2(OP_TRIG, R_P0, R_P0, R_P0, 5'd0);
            S_SEED:
            begin
                unique case (step_reg) inside
                    5'd0:          cmd = op2(OP_MOV, R_P1, R_P1, R_PM, 5'd0);
                    [5'd1:5'd4]:   cmd = fm(2'(step_reg - 5'd1), R_P1, C_SIN, R_T0, 5'd0);
                    default:       cmd = op2(OP_IMUL, R_T0, R_T0, R_P1, kseed);
                endcase
            end
            S_SEEDD:
            begin
                unique case (step_reg) inside
                    [5'd0:5'd3]:   cmd = fm(step_reg[1:0], R_PM, C_COS, R_T0, 5'd0);
                    5'd4:          cmd = op2(OP_IMUL, R_T0, R_T0, R_T0, k2m);
                    default:       cmd = op2(OP_IMUL, R_T0, R_T0, R_D1, 5'(m_reg));
                endcase
            end
            S_REC:
            begin
                unique case (step_reg) inside
                    [5'd0:5'd3]:   cmd = fm(step_reg[1:0], R_D1, C_COS, R_T0, 5'd0);
                    [5'd4:5'd7]:   cmd = fm(step_reg[1:0], R_P1, C_SIN, R_T1, 5'd0);
                    5'd8:          cmd = op2(OP_SUB, R_T0, R_T1, R_T0, 5'd0);
                    5'd9:          cmd = op2(OP_IMUL, R_T0, R_T0, R_T0, k1);
                    5'd10:         cmd = op2(OP_IMUL, R_D0, R_D0, R_T1, k2);
                    5'd11:         cmd = op2(OP_SUB, R_T0, R_T1, R_T0, 5'd0);
                    [5'd12:5'd15]: cmd = fm(step_reg[1:0], R_T0, C_RECIP, R_T2, ridx);
                    [5'd16:5'd19]: cmd = fm(step_reg[1:0], R_P1, C_COS, R_T0, 5'd0);
                    5'd20:         cmd = op2(OP_IMUL, R_T0, R_T0, R_T0, k1);
                    5'd21:         cmd = op2(OP_IMUL, R_P0, R_P0, R_T1, k2);
                    5'd22:         cmd = op2(OP_SUB, R_T0, R_T1, R_T0, 5'd0);
                    [5'd23:5'd26]: cmd = fm(2'(step_reg - 5'd23), R_T0, C_RECIP, R_T0, ridx);
                    default:       cmd = op2(OP_SHIFT, R_P0, R_P0, R_P0, 5'd0);
                endcase
            end
            S_DONE:     cmd = op2(OP_OUT, R_P0, R_P0, R_P0, 5'd0);
            default:    cmd = op2(OP_OUTERR, R_P0, R_P0, R_P0, 5'd0);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            m_reg     <= '0;
            i_reg     <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg    <= n_in;
                        m_reg    <= m_in;
                        step_reg <= '0;
                        state_reg <= (m_in > n_in) ? S_DONE_ERR : S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(CORDIC_STEPS - 1)) state_reg <= S_TRIG;
                end
                S_TRIG:
                begin
                    step_reg <= '0;
                    if (m_reg != 4'd0)
                    begin
                        i_reg     <= 4'd1;
                        state_reg <= S_SEED;
                    end
                    else if (n_reg != 4'd0)
                    begin
                        i_reg     <= 4'd1;
                        state_reg <= S_REC;
                    end
                    else state_reg <= S_DONE;
                end
                S_SEED:
                begin
                    if (step_reg == 5'd5)
                    begin
                        step_reg <= '0;
                        if (i_reg == m_reg) state_reg <= S_SEEDD;
                        else i_reg <= i_reg + 4'd1;
                    end
                    else step_reg <= step_reg + 5'd1;
                end
                S_SEEDD:
                begin
                    if (step_reg == 5'd5)
                    begin
                        step_reg <= '0;
                        i_reg    <= m_reg + 4'd1;
                        state_reg <= (n_reg == m_reg) ? S_DONE : S_REC;
                    end
                    else step_reg <= step_reg + 5'd1;
                end
                S_REC:
                begin
                    if (step_reg == 5'd27)
                    begin
                        step_reg <= '0;
                        if (i_reg == n_reg) state_reg <= S_DONE;
                        else i_reg <= i_reg + 4'd1;
                    end
                    else step_reg <= step_reg + 5'd1;
                end
                default:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== sv/ale_dpath.sv =====
// ----------------------------------------------------------------------------
// ale_dpath
// Datapath: CORDIC rotator, value registers, a shared 32x32-class fraction
// multiplier (split over partial products), integer scaler and saturating
// subtractor, plus the result registers.
// ----------------------------------------------------------------------------
module ale_dpath
    import ale_pkg::*;
(
    input  logic                 clk,
    input  cmd_t                 cmd,
    input  logic signed [30:0]   theta,
    output logic signed [VW-1:0] func_value,
    output logic signed [VW-1:0] deriv_value,
    output logic                 order_error,
    output logic                 saturated
);

    logic signed [AW-1:0] x_reg, y_reg, z_reg, cos_reg, sin_reg;
    logic                 flip_reg, sat_reg, neg_reg;
    logic signed [VW-1:0] p0_reg, p1_reg, d0_reg, d1_reg, pm_reg;
    logic signed [VW-1:0] t0_reg, t1_reg, t2_reg;
    logic [VW-1:0]        ua_reg;
    logic [30:0]          uc_reg;
    logic [60:0]          plo_reg;
    logic [58:0]          phi_reg;
    logic signed [VW-1:0] func_reg, deriv_reg;
    logic                 err_reg, osat_reg;

    logic signed [VW-1:0] a_val, b_val;
    logic signed [AW-1:0] c_val, xs, ys, z_ext, z_fold, atan_s;
    logic [VW-1:0]        a_mag;
    logic [AW-1:0]        c_mag;
    logic [30:0]          uc_clamp;
    logic [62:0]          imul_prod;
    logic [61:0]          lo_rnd;
    logic [59:0]          fend_sum;
    logic [30:0]          mul_b;
    logic [29:0]          mul_a;
    logic [60:0]          mul_p;
    logic [VW:0]          wres;
    logic                 wr;
    logic                 fold_hi, fold_lo;

    always_comb
    begin
        unique case (cmd.src_a)
            R_P0: a_val = p0_reg;
            R_P1: a_val = p1_reg;
            R_D0: a_val = d0_reg;
            R_D1: a_val = d1_reg;
            R_PM: a_val = pm_reg;
            R_T0: a_val = t0_reg;
            R_T1: a_val = t1_reg;
            default: a_val = t2_reg;
        endcase
        unique case (cmd.src_b)
            R_P0: b_val = p0_reg;
            R_P1: b_val = p1_reg;
            R_D0: b_val = d0_reg;
            R_D1: b_val = d1_reg;
            R_PM: b_val = pm_reg;
            R_T0: b_val = t0_reg;
            R_T1: b_val = t1_reg;
            default: b_val = t2_reg;
        endcase
        unique case (cmd.coef)
            C_COS: c_val = cos_reg;
            C_SIN: c_val = sin_reg;
            default: c_val = AW'($signed({1'b0, recip_val(cmd.kval[3:0])}));
        endcase
    end

    assign a_mag    = a_val[VW-1] ? VW'(-a_val) : VW'(a_val);
    assign c_mag    = c_val[AW-1] ? AW'(-c_val) : AW'(c_val);
    assign uc_clamp = (c_mag > AW'(34'h07FFFFFFF)) ? 31'h7FFFFFFF : c_mag[30:0];
    assign imul_prod = 63'(a_mag) * 63'(cmd.kval);

    // one multiplier serves both halves of the magnitude
    assign mul_a = (cmd.op == OP_FLO) ? ua_reg[29:0] : {2'b00, ua_reg[VW-1:30]};
    assign mul_b = uc_reg;
    assign mul_p = 61'(mul_a) * 61'(mul_b);

    assign lo_rnd   = {1'b0, plo_reg} + 62'h0000_0000_2000_0000;
    assign fend_sum = 60'(phi_reg) + 60'(lo_rnd[61:30]);

    // angle fold into -pi/2..pi/2
    assign z_ext   = AW'(theta) <<< 2;
    assign fold_hi = (z_ext > HALF_PI_Q30);
    assign fold_lo = (z_ext < -HALF_PI_Q30);
    assign z_fold  = fold_hi ? (z_ext - PI_Q30) : (fold_lo ? (z_ext + PI_Q30) : z_ext);

    assign xs     = x_reg >>> cmd.kval;
    assign ys     = y_reg >>> cmd.kval;
    assign atan_s = AW'($signed({1'b0, atan_val(cmd.kval)}));

    always_comb
    begin
        wr   = 1'b0;
        wres = {1'b0, a_val};
        unique case (cmd.op)
            OP_FEND: begin wr = 1'b1; wres = sat_sign(64'(fend_sum), neg_reg); end
            OP_IMUL: begin wr = 1'b1; wres = sat_sign(64'(imul_prod), a_val[VW-1]); end
            OP_SUB:
            begin
                wr   = 1'b1;
                wres = clip_wide({a_val[VW-1], a_val} - {b_val[VW-1], b_val});
            end
            OP_MOV:  wr = 1'b1;
            default: wr = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= z_fold;
                flip_reg <= fold_hi | fold_lo;
                sat_reg  <= 1'b0;
                p1_reg   <= ONE_Q32;
                pm_reg   <= '0;
                d1_reg   <= '0;
                p0_reg   <= '0;
                d0_reg   <= '0;
            end
            OP_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_s;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_s;
                end
            end
            OP_TRIG:
            begin
                cos_reg <= flip_reg ? -x_reg : x_reg;
                sin_reg <= flip_reg ? -y_reg : y_reg;
            end
            OP_FSET:
            begin
                ua_reg  <= a_mag;
                uc_reg  <= uc_clamp;
                neg_reg <= a_val[VW-1] ^ c_val[AW-1];
            end
            OP_FLO:   plo_reg <= mul_p;
            OP_FHI:   phi_reg <= mul_p[58:0];
            OP_SHIFT:
            begin
                p0_reg <= p1_reg;
                p1_reg <= t0_reg;
                d0_reg <= d1_reg;
                d1_reg <= t2_reg;
            end
            OP_OUT:
            begin
                func_reg  <= p1_reg;
                deriv_reg <= d1_reg;
                err_reg   <= 1'b0;
                osat_reg  <= sat_reg;
            end
            OP_OUTERR:
            begin
                func_reg  <= '0;
                deriv_reg <= '0;
                err_reg   <= 1'b1;
                osat_reg  <= 1'b0;
            end
            default: ;
        endcase

        if (wr)
        begin
            sat_reg <= sat_reg | wres[VW];
            unique case (cmd.dst)
                R_P0: p0_reg <= wres[VW-1:0];
                R_P1: p1_reg <= wres[VW-1:0];
                R_D0: d0_reg <= wres[VW-1:0];
                R_D1: d1_reg <= wres[VW-1:0];
                R_PM: pm_reg <= wres[VW-1:0];
                R_T0: t0_reg <= wres[VW-1:0];
                R_T1: t1_reg <= wres[VW-1:0];
                default: t2_reg <= wres[VW-1:0];
            endcase
        end
    end

    assign func_value  = func_reg;
    assign deriv_value = deriv_reg;
    assign order_error = err_reg;
    assign saturated   = osat_reg;

endmodule

// ===== sv/assoc_legendre_eval_core.sv =====
// ----------------------------------------------------------------------------
// assoc_legendre_eval_core
// Evaluates P(n,m)(cos theta) and dP/dtheta by upward recurrence in degree.
// ----------------------------------------------------------------------------
// Usage:
//   Drive degree, order and theta (Q2.28) and raise start; the beat is taken
//   at a clock edge with start high and busy low. busy stays high until the
//   result is ready. The result beat is on func_value, deriv_value (Q25.32),
//   order_error and saturated for exactly one cycle, marked by done; the
//   receiver cannot stall it, and a new start may be given in that cycle.
//   Work runs through the 32-step CORDIC, then the seed and the degree
//   recurrence, with n, m clamped to MAX_DEGREE. Each recurrence step runs
//   through the shared fraction multiplier five times, forming each product
//   from its partial products in turn. An order above degree sends the
//   sequencer straight to its error state, which raises done. One item is in flight at a time.
//   Reset clears the sequencer: busy and done low; result ports hold no
//   meaning until the first done.
// ----------------------------------------------------------------------------
module assoc_legendre_eval_core
    import ale_pkg::*;
#(
    parameter int MAX_DEGREE = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [3:0]           degree,
    input  logic [3:0]           order,
    input  logic signed [30:0]   theta,
    output logic                 done,
    output logic signed [VW-1:0] func_value,
    output logic signed [VW-1:0] deriv_value,
    output logic                 order_error,
    output logic                 saturated
);

    cmd_t cmd;

    ale_ctrl #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .degree (degree),
        .order  (order),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    ale_dpath u_dpath (
        .clk         (clk),
        .cmd         (cmd),
        .theta       (theta),
        .func_value  (func_value),
        .deriv_value (deriv_value),
        .order_error (order_error),
        .saturated   (saturated)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start work");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && order_error) |-> (func_value == '0 && deriv_value == '0 && !saturated))
        else $error("order error with nonzero result");

endmodule
